[design/etc_pkg.sv]
// Shared types and constants for the encoder turn controller.
`timescale 1ns / 1ps
`default_nettype none
package etc_pkg;

  // Default widths
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Port field widths
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int TARGET_W    = 16;
  localparam int SPEED_W     = 7;
  localparam int DRIVE_W     = 8;

  // Log2 of the distance clamp before the fraction, in counts
  localparam int DIST_CLAMP_LOG2 = 21;

  // Speed breakpoints for the stop fraction
  localparam int SPD_BREAK_1 = 21;
  localparam int SPD_BREAK_2 = 42;
  localparam int SPD_BREAK_3 = 75;
  localparam int SPD_BREAK_4 = 100;
  // Speed around which the turn-end rule changes
  localparam int SPD_END     = 65;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_LEFT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_RIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_LEFT   = 3'd4;

  // Register reset values
  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd16;

  // Configuration register file contents
  typedef struct packed {
    logic [CFG_DATA_W-1:0] start_left;
    logic [CFG_DATA_W-1:0] start_right;
    logic [TARGET_W-1:0]   target_counts;
    logic [SPEED_W-1:0]    turn_speed;
    logic                  turn_left;
  } etc_cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIV_L_GO,
    ST_DIV_L_WAIT,
    ST_DIV_R_GO,
    ST_DIV_R_WAIT,
    ST_MUL_L,
    ST_MUL_R,
    ST_DECIDE,
    ST_OUT
  } etc_state_t;

endpackage
`default_nettype wire

[design/etc_if.sv]
// Handshake channels for encoder samples and motor results.
`timescale 1ns / 1ps
`default_nettype none
interface etc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_count;
  logic [31:0] right_count;

  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface etc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_drive;
  logic [7:0] right_drive;
  logic       command_valid;
  logic       turn_done;

  modport source (output valid, left_drive, right_drive, command_valid, turn_done,
                  input ready);
  modport sink (input valid, left_drive, right_drive, command_valid, turn_done,
                output ready);
endinterface
`default_nettype wire

[design/etc_cfg.sv]
// Configuration register file with restart strobe.
`timescale 1ns / 1ps
`default_nettype none
module etc_cfg
  import etc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output etc_cfg_t                    cfg,
  output logic                        restart
);

  // Any write to a known register restarts the turn
  always_comb begin
    case (cfg_index)
      REG_START_LEFT, REG_START_RIGHT, REG_TARGET,
      REG_SPEED, REG_TURN_LEFT: restart = cfg_we;
      default:                  restart = 1'b0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_left    <= '0;
      cfg.start_right   <= '0;
      cfg.target_counts <= TARGET_RESET;
      cfg.turn_speed    <= '0;
      cfg.turn_left     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_LEFT:  cfg.start_left    <= cfg_data;
        REG_START_RIGHT: cfg.start_right   <= cfg_data;
        REG_TARGET:      cfg.target_counts <= cfg_data[TARGET_W-1:0];
        REG_SPEED:       cfg.turn_speed    <= cfg_data[SPEED_W-1:0];
        REG_TURN_LEFT:   cfg.turn_left     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/etc_frac_div.sv]
// Serial divider for the remaining-angle fraction, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module etc_frac_div
  import etc_pkg::*;
#(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [COUNT_WIDTH:0]         dist_in,
  input  wire logic [TARGET_W-1:0]          target,
  output logic                              done,
  output logic signed [FRACTION_BITS+3:0]   frac
);

  localparam int FW     = FRACTION_BITS + 4;
  localparam int SW     = FRACTION_BITS + 3;
  localparam int DCW    = DIST_CLAMP_LOG2 + 1;
  localparam int DW     = (COUNT_WIDTH + 1 > DCW) ? COUNT_WIDTH + 1 : DCW;
  localparam int NW     = DCW + 5;
  localparam int CNT_W  = $clog2(SW + 1);
  localparam logic [DW-1:0]  CLAMP_W = DW'(1) << DIST_CLAMP_LOG2;
  localparam logic [FW-1:0]  Q_MAX   = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0]  Q_MIN   = {1'b1, {(FW-1){1'b0}}};
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(SW);

  logic [DW-1:0]        dist_w;
  logic [DCW-1:0]       dist_c;
  logic signed [NW-1:0] num;
  logic                 num_neg;
  logic [NW-1:0]        num_mag;
  logic                 sat;

  logic [TARGET_W-1:0]  div_t;
  logic [TARGET_W-1:0]  rem;
  logic [SW-1:0]        sh;
  logic                 neg;
  logic                 busy;
  logic [CNT_W-1:0]     cnt;

  logic [TARGET_W:0]    rem_sh;
  logic [TARGET_W+1:0]  diff;
  logic                 qbit;
  logic [TARGET_W-1:0]  rem_next;
  logic [SW-1:0]        sh_next;

  // Setup: clamp distance, numerator t - 16*d, magnitude, saturation test
  always_comb begin
    dist_w  = DW'(dist_in);
    dist_c  = (dist_w > CLAMP_W) ? CLAMP_W[DCW-1:0] : dist_w[DCW-1:0];
    num     = signed'(NW'(target)) - signed'({1'b0, dist_c, 4'b0000});
    num_neg = num[NW-1];
    num_mag = num_neg ? NW'(-num) : NW'(num);
    sat     = num_mag >= NW'({target, 3'b000});
  end

  // One restoring step
  always_comb begin
    rem_sh   = {rem, sh[SW-1]};
    diff     = {1'b0, rem_sh} - {2'b00, div_t};
    qbit     = ~diff[TARGET_W+1];
    rem_next = qbit ? diff[TARGET_W-1:0] : rem_sh[TARGET_W-1:0];
    sh_next  = {sh[SW-2:0], qbit};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      div_t <= target;
      neg   <= num_neg;
      cnt   <= STEPS;
      rem   <= num_mag[TARGET_W+2:3];
      sh    <= {num_mag[2:0], {FRACTION_BITS{1'b0}}};
      if (sat) begin
        frac <= num_neg ? signed'(Q_MIN) : signed'(Q_MAX);
      end
    end else if (busy) begin
      rem <= rem_next;
      sh  <= sh_next;
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        frac <= neg ? -signed'(FW'(sh_next)) : signed'(FW'(sh_next));
      end
    end
  end

endmodule
`default_nettype wire

[design/encoder_turn_controller_core.sv]
// Top level: sequencer and datapath of the encoder turn controller.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    left_count, right_count
//  out_ch   out  valid / ready    left_drive, right_drive, command_valid, turn_done
//  cfg      in   cfg_we           cfg_index, cfg_data
//
// Each sample is worked on in turn: the fraction divider yields one quotient bit a
// cycle and runs once per wheel. A saturated fraction skips its divide; a sample
// after the turn ended skips the computation and goes straight to out_ch.
// Synchronous reset; no clearing pass. Ready is low while a sample is worked on,
// and the result holds on out_ch until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module encoder_turn_controller_core
  import etc_pkg::*;
#(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  etc_in_if.sink                      in_ch,
  etc_out_if.source                   out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = COUNT_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int FW = FB + 4;
  localparam int XW = CW + 2;
  localparam int PW = FW + 8;
  localparam int QW = FB + 13;
  localparam int ONE_I = 1 << FB;
  localparam logic signed [QW-1:0] ONE_Q   = QW'(1) << FB;
  localparam logic signed [FW-1:0] STOP_1  = FW'((1 * ONE_I + 5) / 10);
  localparam logic signed [FW-1:0] STOP_2  = FW'((2 * ONE_I + 5) / 10);
  localparam logic signed [FW-1:0] STOP_3  = FW'((3 * ONE_I + 5) / 10);
  localparam logic signed [FW-1:0] STOP_4  = FW'((4 * ONE_I + 5) / 10);
  localparam logic signed [FW-1:0] STOP_5  = FW'((5 * ONE_I + 5) / 10);

  etc_cfg_t   cfg;
  logic       restart;
  etc_state_t state, state_next;

  // Per-sample state
  logic [CW-1:0]        cur_left, cur_right;
  logic [CW-1:0]        last_left, last_right;
  logic                 first_sample, corrected_mark, finished;
  logic [CW:0]          dist_left, dist_right;
  logic signed [FW-1:0] frac_left, frac_right;
  logic signed [QW-1:0] q_left, q_right;

  // Result registers
  logic [DRIVE_W-1:0]   left_drive, right_drive;
  logic                 command_valid, turn_done;

  logic                 div_start, div_done;
  logic [CW:0]          div_dist;
  logic signed [FW-1:0] div_frac;
  logic [TARGET_W-1:0]  target_eff;

  etc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  assign target_eff = (cfg.target_counts == '0) ? TARGET_W'(1) : cfg.target_counts;
  assign div_dist   = (state == ST_DIV_R_GO) ? dist_right : dist_left;
  assign div_start  = (state == ST_DIV_L_GO) || (state == ST_DIV_R_GO);

  etc_frac_div #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dist_in (div_dist),
    .target  (target_eff),
    .done    (div_done),
    .frac    (div_frac)
  );

  // Distance d = |2*count - start - previous|
  logic signed [XW-1:0] sl_x, sr_x, cl_x, cr_x, pl_x, pr_x, dl_x, dr_x;
  always_comb begin
    sl_x = signed'({{2{cfg.start_left[CW-1]}},  cfg.start_left[CW-1:0]});
    sr_x = signed'({{2{cfg.start_right[CW-1]}}, cfg.start_right[CW-1:0]});
    cl_x = signed'({{2{cur_left[CW-1]}},  cur_left});
    cr_x = signed'({{2{cur_right[CW-1]}}, cur_right});
    pl_x = first_sample ? sl_x : signed'({{2{last_left[CW-1]}},  last_left});
    pr_x = first_sample ? sr_x : signed'({{2{last_right[CW-1]}}, last_right});
    dl_x = (cl_x <<< 1) - sl_x - pl_x;
    dr_x = (cr_x <<< 1) - sr_x - pr_x;
  end

  // Shared multiplier: s * (f * speed + 1)
  logic signed [FW-1:0] mul_f;
  logic signed [PW-1:0] mul_p;
  logic signed [QW-1:0] mul_sum;
  logic                 mul_negate;
  always_comb begin
    mul_f      = (state == ST_MUL_R) ? frac_right : frac_left;
    mul_p      = mul_f * signed'({1'b0, cfg.turn_speed});
    mul_sum    = QW'(mul_p) + ONE_Q;
    // left wheel runs backward on a left turn, right wheel on a right turn
    mul_negate = (state == ST_MUL_R) ? ~cfg.turn_left : cfg.turn_left;
  end

  // Decision
  logic signed [FW-1:0]  stop_pos, stop_neg;
  logic                  go_full, go_rev, in_band, mark_now, hit;
  logic [DRIVE_W-1:0]    spd_fwd, spd_bwd, sgn_left, sgn_right;
  logic [DRIVE_W-1:0]    vl, vr;
  logic signed [QW-1:0]  tq_left, tq_right;
  logic [TARGET_W-1:0]   whole;
  always_comb begin
    if (cfg.turn_speed < SPEED_W'(SPD_BREAK_1))      stop_pos = STOP_1;
    else if (cfg.turn_speed < SPEED_W'(SPD_BREAK_2)) stop_pos = STOP_2;
    else if (cfg.turn_speed < SPEED_W'(SPD_BREAK_3)) stop_pos = STOP_3;
    else if (cfg.turn_speed < SPEED_W'(SPD_BREAK_4)) stop_pos = STOP_4;
    else                                             stop_pos = STOP_5;
    stop_neg = -stop_pos;

    go_full = (frac_left > stop_pos) || (frac_right > stop_pos);
    go_rev  = (frac_left < stop_neg) || (frac_right < stop_neg);
    in_band = (q_left > -ONE_Q) && (q_left < ONE_Q) &&
              (q_right > -ONE_Q) && (q_right < ONE_Q);

    spd_fwd   = {1'b0, cfg.turn_speed};
    spd_bwd   = -spd_fwd;
    sgn_left  = cfg.turn_left ? '1 : DRIVE_W'(1);
    sgn_right = cfg.turn_left ? DRIVE_W'(1) : '1;

    // truncate toward zero
    tq_left  = (q_left  + (q_left[QW-1]  ? ONE_Q - QW'(1) : '0)) >>> FB;
    tq_right = (q_right + (q_right[QW-1] ? ONE_Q - QW'(1) : '0)) >>> FB;

    mark_now = corrected_mark;
    if (go_full) begin
      vl = cfg.turn_left ? spd_bwd : spd_fwd;
      vr = cfg.turn_left ? spd_fwd : spd_bwd;
    end else if (go_rev) begin
      vl = cfg.turn_left ? spd_fwd : spd_bwd;
      vr = cfg.turn_left ? spd_bwd : spd_fwd;
    end else if (in_band) begin
      mark_now = 1'b1;
      vl = sgn_right;
      vr = sgn_left;
    end else begin
      vl = tq_left[DRIVE_W-1:0];
      vr = tq_right[DRIVE_W-1:0];
    end

    whole = target_eff >> 4;
    hit   = (dist_left == (CW+1)'(whole)) && (dist_right == (CW+1)'(whole));
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_ch.valid) state_next = finished ? ST_OUT : ST_DIST;
      ST_DIST:       state_next = ST_DIV_L_GO;
      ST_DIV_L_GO:   state_next = ST_DIV_L_WAIT;
      ST_DIV_L_WAIT: if (div_done) state_next = ST_DIV_R_GO;
      ST_DIV_R_GO:   state_next = ST_DIV_R_WAIT;
      ST_DIV_R_WAIT: if (div_done) state_next = ST_MUL_L;
      ST_MUL_L:      state_next = ST_MUL_R;
      ST_MUL_R:      state_next = ST_DECIDE;
      ST_DECIDE:     state_next = ST_OUT;
      ST_OUT:        if (out_ch.ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready          = (state == ST_IDLE);
  assign out_ch.valid         = (state == ST_OUT);
  assign out_ch.left_drive    = left_drive;
  assign out_ch.right_drive   = right_drive;
  assign out_ch.command_valid = command_valid;
  assign out_ch.turn_done     = turn_done;

  // Turn state flags
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      first_sample   <= 1'b1;
      corrected_mark <= 1'b0;
      finished       <= 1'b0;
    end else begin
      if (state == ST_DIST) first_sample <= 1'b0;
      if (state == ST_DECIDE) begin
        if (hit && cfg.turn_speed > SPEED_W'(SPD_END) && mark_now) begin
          corrected_mark <= 1'b0;
          finished       <= 1'b1;
        end else begin
          corrected_mark <= mark_now;
          if (hit && cfg.turn_speed < SPEED_W'(SPD_END)) finished <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_left      <= in_ch.left_count[CW-1:0];
        cur_right     <= in_ch.right_count[CW-1:0];
        left_drive    <= '0;
        right_drive   <= '0;
        command_valid <= 1'b0;
        turn_done     <= 1'b0;
      end
      ST_DIST: begin
        dist_left  <= dl_x[XW-1] ? (CW+1)'(-dl_x) : (CW+1)'(dl_x);
        dist_right <= dr_x[XW-1] ? (CW+1)'(-dr_x) : (CW+1)'(dr_x);
        last_left  <= cur_left;
        last_right <= cur_right;
      end
      ST_DIV_L_WAIT: if (div_done) frac_left <= div_frac;
      ST_DIV_R_WAIT: if (div_done) frac_right <= div_frac;
      ST_MUL_L:      q_left  <= mul_negate ? -mul_sum : mul_sum;
      ST_MUL_R:      q_right <= mul_negate ? -mul_sum : mul_sum;
      ST_DECIDE: begin
        if (hit) begin
          if ((cfg.turn_speed > SPEED_W'(SPD_END) && mark_now) ||
              cfg.turn_speed < SPEED_W'(SPD_END)) begin
            turn_done <= 1'b1;
          end
        end else begin
          left_drive    <= vl;
          right_drive   <= vr;
          command_valid <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[dv/encoder_turn_controller_core_tb.sv]
// Self-checking testbench for the encoder turn controller core: predictor, drivers and checks.
`timescale 1ns / 1ps
module encoder_turn_controller_core_tb;
  import etc_pkg::*;

  localparam int     QBITS       = FRACTION_BITS_DEF;
  localparam longint Q_ONE       = longint'(1) << QBITS;
  localparam longint Q_HI        = (longint'(8) << QBITS) - 1;
  localparam longint Q_LO        = -(longint'(8) << QBITS);
  localparam longint D_CLAMP     = longint'(1) << DIST_CLAMP_LOG2;
  localparam int     IDLE_LIMIT  = 2000;
  localparam int     N_ITEMS     = 1150;
  localparam int     HOLD_CYCLES = 300;
  localparam int     MAX_REPORTS = 200;

  // One motor result as seen on the output channel
  typedef struct packed {
    logic [DRIVE_W-1:0] left_drive;
    logic [DRIVE_W-1:0] right_drive;
    logic               command_valid;
    logic               turn_done;
  } motor_cmd_t;

  // Turn predictor and queue of expected motor results
  class turn_scoreboard;
    longint      start_l, start_r;
    int unsigned target, speed;
    bit          ccw;
    longint      prev_l, prev_r;
    bit          fresh, corrected, ended;
    motor_cmd_t  want_q[$];
    int          n_err, n_samples, n_cmds, n_ends, n_corr;

    function new();
      start_l   = 0;
      start_r   = 0;
      target    = TARGET_RESET;
      speed     = 0;
      ccw       = 0;
      n_err     = 0;
      n_samples = 0;
      n_cmds    = 0;
      n_ends    = 0;
      n_corr    = 0;
      restart();
    endfunction

    function void restart();
      prev_l    = 0;
      prev_r    = 0;
      fresh     = 1;
      corrected = 0;
      ended     = 0;
    endfunction

    // any register write restarts the turn
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_START_LEFT:  start_l = longint'($signed(val));
        REG_START_RIGHT: start_r = longint'($signed(val));
        REG_TARGET:      target  = val[TARGET_W-1:0];
        REG_SPEED:       speed   = val[SPEED_W-1:0];
        REG_TURN_LEFT:   ccw     = val[0];
        default:         return;
      endcase
      restart();
    endfunction

    // remaining fraction of the turn, Q4.16, saturated
    function longint frac_left(longint span, longint t);
      longint dc, p;
      dc = (span > D_CLAMP) ? D_CLAMP : span;
      p  = ((t - 16 * dc) * Q_ONE) / t;
      if (p > Q_HI) p = Q_HI;
      if (p < Q_LO) p = Q_LO;
      return p;
    endfunction

    // stop fraction k/10 picked by speed band, rounded half up
    function longint stop_frac();
      longint k;
      if (speed < SPD_BREAK_1) k = 1;
      else if (speed < SPD_BREAK_2) k = 2;
      else if (speed < SPD_BREAK_3) k = 3;
      else if (speed < SPD_BREAK_4) k = 4;
      else k = 5;
      return (k * Q_ONE + 5) / 10;
    endfunction

    function void note_sample(logic [31:0] lc, logic [31:0] rc);
      longint     cl, cr, pl, pr, dl, dr, t, fl, fr, stop, spd, ls, rs, vl, vr, ql, qr;
      motor_cmd_t res;
      res = '0;
      n_samples++;
      // after the turn ended every result is all zero
      if (ended) begin
        want_q.push_back(res);
        return;
      end
      cl     = longint'($signed(lc));
      cr     = longint'($signed(rc));
      pl     = fresh ? start_l : prev_l;
      pr     = fresh ? start_r : prev_r;
      fresh  = 0;
      prev_l = cl;
      prev_r = cr;

      // distance covered per wheel
      dl = 2 * cl - start_l - pl;
      dr = 2 * cr - start_r - pr;
      if (dl < 0) dl = -dl;
      if (dr < 0) dr = -dr;

      t    = (target == 0) ? 1 : longint'(target);
      fl   = frac_left(dl, t);
      fr   = frac_left(dr, t);
      spd  = longint'(speed);
      stop = stop_frac();
      ls   = ccw ? -1 : 1;
      rs   = -ls;

      // full speed, reversed full speed, or proportional drive
      if (fl > stop || fr > stop) begin
        vl = spd * ls;
        vr = spd * rs;
      end else if (fl < -stop || fr < -stop) begin
        vl = spd * rs;
        vr = spd * ls;
      end else begin
        ql = ls * (fl * spd + Q_ONE);
        qr = rs * (fr * spd + Q_ONE);
        // both drives under one: nudge with swapped signs
        if (ql > -Q_ONE && ql < Q_ONE && qr > -Q_ONE && qr < Q_ONE) begin
          corrected = 1;
          n_corr++;
          vl = rs;
          vr = ls;
        end else begin
          vl = ql / Q_ONE;
          vr = qr / Q_ONE;
        end
      end

      // target reached on both wheels
      if (dl == (t >>> 4) && dr == (t >>> 4)) begin
        if (speed > SPD_END && corrected) begin
          corrected     = 0;
          ended         = 1;
          res.turn_done = 1'b1;
        end else if (speed < SPD_END) begin
          ended         = 1;
          res.turn_done = 1'b1;
        end
        if (res.turn_done) n_ends++;
      end else begin
        res.left_drive    = vl[DRIVE_W-1:0];
        res.right_drive   = vr[DRIVE_W-1:0];
        res.command_valid = 1'b1;
        n_cmds++;
      end
      want_q.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        if (n_err == MAX_REPORTS)
          $display("%0t ns: further mismatch reports suppressed", $time);
      end
    endfunction

    function void check_result(motor_cmd_t got);
      motor_cmd_t want;
      if (want_q.size() == 0) begin
        n_err++;
        $display("%0t ns: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = want_q.pop_front();
      compare_field("left_drive", $signed(want.left_drive), $signed(got.left_drive));
      compare_field("right_drive", $signed(want.right_drive), $signed(got.right_drive));
      compare_field("command_valid", {31'd0, want.command_valid}, {31'd0, got.command_valid});
      compare_field("turn_done", {31'd0, want.turn_done}, {31'd0, got.turn_done});
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  etc_in_if  in_ch ();
  etc_out_if out_ch ();

  turn_scoreboard sb = new();

  bit     tx_steady   = 1'b0;
  bit     rx_steady   = 1'b0;
  bit     hold_req    = 1'b0;
  longint gen_l       = 0;
  longint gen_r       = 0;
  int     n_items     = 0;
  int     n_settings  = 1;
  int     idle_cycles = 0;

  encoder_turn_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog: cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int         gap;
    motor_cmd_t got;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = {out_ch.left_drive, out_ch.right_drive, out_ch.command_valid, out_ch.turn_done};
      sb.check_result(got);
    end
  end

  task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.left_count  <= lc;
    in_ch.right_count <= rc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(lc, rc);
    gen_l = longint'($signed(lc));
    gen_r = longint'($signed(rc));
  endtask

  // Stop offering and wait until the block has delivered everything
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Write every register; unused upper data bits carry noise
  task automatic program_turn(input logic [31:0] sl, input logic [31:0] sr,
                              input logic [15:0] tgt, input logic [6:0] spd, input logic ccw);
    logic [31:0] junk;
    junk = $urandom();
    reg_write(REG_START_LEFT, sl);
    reg_write(REG_START_RIGHT, sr);
    reg_write(REG_TARGET, {junk[31:16], tgt});
    reg_write(REG_SPEED, {junk[31:7], spd});
    reg_write(REG_TURN_LEFT, {junk[31:1], ccw});
    cfg_we <= 1'b0;
    n_settings++;
    gen_l = longint'($signed(sl));
    gen_r = longint'($signed(sr));
  endtask

  task automatic random_setting();
    logic [31:0] sl, sr;
    logic [15:0] tgt;
    logic [6:0]  spd;
    sl = $urandom();
    sr = $urandom();
    if ($urandom_range(0, 3) != 0) sl = {{12{sl[19]}}, sl[19:0]};
    if ($urandom_range(0, 3) != 0) sr = {{12{sr[19]}}, sr[19:0]};
    case ($urandom_range(0, 3))
      0:       tgt = 16'($urandom_range(0, 255));
      1:       tgt = 16'($urandom_range(256, 4095));
      2:       tgt = 16'($urandom_range(4096, 24000));
      default: tgt = 16'($urandom());
    endcase
    // lean on the speed band edges and the turn-end speed
    case ($urandom_range(0, 7))
      0:       spd = 7'(SPD_BREAK_1 - 1 + $urandom_range(0, 1));
      1:       spd = 7'(SPD_BREAK_2 - 1 + $urandom_range(0, 1));
      2:       spd = 7'(SPD_BREAK_3 - 1 + $urandom_range(0, 1));
      3:       spd = 7'(SPD_BREAK_4 - 1 + $urandom_range(0, 1));
      4:       spd = 7'(SPD_END - 1 + $urandom_range(0, 2));
      5:       spd = $urandom_range(0, 1) ? 7'd0 : 7'd127;
      default: spd = 7'($urandom_range(0, 127));
    endcase
    program_turn(sl, sr, tgt, spd, 1'($urandom_range(0, 1)));
  endtask

  // Counts that put the given signed distance on a wheel
  function automatic logic [31:0] count_for(longint start, longint prev, longint span);
    return 32'((start + prev + span) >>> 1);
  endfunction

  // Well-formed turn: ramp toward the target, optional overshoot, exact hit,
  // then a few samples after the end
  task automatic run_turn(input int n_ramp, input bit overshoot, input int extras);
    longint      goal, span, span_r, ls;
    logic [31:0] lc, rc;
    int          total;
    goal  = longint'(sb.target >> 4);
    ls    = sb.ccw ? -1 : 1;
    total = n_ramp + int'(overshoot) + 1;
    for (int i = 0; i < total + extras; i++) begin
      if (i < n_ramp) span = (goal * (i + 1)) / (n_ramp + 1);
      else if (overshoot && i == n_ramp) span = goal + $urandom_range(1, 3);
      else if (i == total - 1) span = goal;
      else span = $urandom_range(0, 32'(2 * goal + 2));
      span_r = span;
      if (i < n_ramp && $urandom_range(0, 7) == 0) span_r = span + 1;
      lc = count_for(sb.start_l, gen_l, ls * span);
      rc = count_for(sb.start_r, gen_r, -ls * span_r);
      // random jump in the middle of the ramp
      if (i < n_ramp - 1 && $urandom_range(0, 11) == 0) begin
        lc = $urandom();
        rc = $urandom();
      end
      // make the final sample able to land exactly on the target
      if (i == total - 2) begin
        if (((sb.start_l + longint'($signed(lc)) + goal) & 1) != 0) lc = lc + 32'd1;
        if (((sb.start_r + longint'($signed(rc)) + goal) & 1) != 0) rc = rc + 32'd1;
      end
      send_sample(lc, rc);
      n_items++;
    end
  endtask

  task automatic noise_burst(input int n);
    logic [31:0] lc, rc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) begin
        lc = $urandom();
        rc = $urandom();
      end else begin
        lc = 32'(gen_l + $urandom_range(0, 64) - 32);
        rc = 32'(gen_r + $urandom_range(0, 64) - 32);
      end
      send_sample(lc, rc);
      n_items++;
    end
  endtask

  initial begin : main_seq
    int phase;
    phase = 0;
    in_ch.valid       <= 1'b0;
    in_ch.left_count  <= '0;
    in_ch.right_count <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: one-count target, zero speed
    send_sample(32'd0, 32'd0);
    send_sample(32'd1, 32'hFFFF_FFFF);
    finish_phase();

    // count extremes, longest target, full speed, left turn
    program_turn(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 7'd127, 1'b1);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    finish_phase();

    // zero target ends at zero distance; later samples give zeros
    program_turn(32'd5, 32'd5, 16'd0, 7'd30, 1'b0);
    send_sample(32'd5, 32'd5);
    send_sample(32'd9, 32'd1);
    finish_phase();

    // speed at the turn-end edge: target reached, turn goes on
    program_turn(32'd0, 32'd0, 16'd64, 7'(SPD_END), 1'b0);
    send_sample(32'd2, 32'hFFFF_FFFE);
    send_sample(32'd3, 32'hFFFF_FFFD);
    finish_phase();

    // fast turn at the target without a correction: no command
    program_turn(32'd0, 32'd0, 16'd64, 7'd100, 1'b1);
    send_sample(32'd2, 32'hFFFF_FFFE);
    finish_phase();

    // one-count overshoot marks a correction, then the fast turn ends
    program_turn(32'd0, 32'd0, 16'd1616, 7'd100, 1'b1);
    send_sample(32'd51, 32'hFFFF_FFCD);
    send_sample(32'd76, 32'hFFFF_FFB4);
    send_sample(32'd0, 32'd0);
    finish_phase();

    // random turns
    n_items = 0;
    while (n_items < N_ITEMS) begin
      phase++;
      random_setting();
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      if (phase == 6) begin
        // receiver stalls long while samples keep coming
        hold_req = 1'b1;
        run_turn(8, 1'b0, 0);
      end else if ($urandom_range(0, 9) == 0) begin
        noise_burst($urandom_range(3, 10));
      end else begin
        run_turn($urandom_range(1, 8), 1'($urandom_range(0, 1)), $urandom_range(0, 2));
      end
      finish_phase();
    end

    repeat (60) @(posedge clk);
    $display("Covered %0d samples under %0d register settings: %0d motor commands,",
             sb.n_samples, n_settings, sb.n_cmds);
    $display("%0d completed turns, %0d corrections, %0d mismatches.",
             sb.n_ends, sb.n_corr, sb.n_err);
    if (sb.n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
